[rtl/iss_pkg.sv]
// ----------------------------------------------------------------------------
// iss_pkg
// Operation codes, status codes and the result record of the sequence store.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int OP_BITS     = 3;
  localparam int POS_BITS    = 7;
  localparam int WORD_BITS   = 32;
  localparam int STATUS_BITS = 2;
  localparam int FOUND_BITS  = 6;
  localparam int COUNT_BITS  = 7;

  localparam logic [OP_BITS-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_BITS-1:0] OP_INS_AT    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_INS_TAIL  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_DEL_FRONT = 3'd3;
  localparam logic [OP_BITS-1:0] OP_DEL_AT    = 3'd4;
  localparam logic [OP_BITS-1:0] OP_DEL_TAIL  = 3'd5;
  localparam logic [OP_BITS-1:0] OP_SEARCH    = 3'd6;
  localparam logic [OP_BITS-1:0] OP_READ      = 3'd7;

  localparam logic [STATUS_BITS-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_IGNORED   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [COUNT_BITS-1:0]  count;
    logic [WORD_BITS-1:0]   read_value;
    logic [FOUND_BITS-1:0]  found_position;
    logic [STATUS_BITS-1:0] status;
  } res_t;

endpackage

[rtl/indexed_sequence_store_top.sv]
// ----------------------------------------------------------------------------
// indexed_sequence_store_top
// Ordered store of up to DEPTH signed words with insert, delete, search and
// read by position; one result beat per input beat.
//
//   channel  dir  tdata fields (low bit up)
//   in_      in   op[2:0] position[9:3] value[41:10]
//   out_     out  status[1:0] found_position[7:2] read_value[39:8] count[46:40]
//
// Insert and delete walk the entries that must move, search walks the entries
// until a match or the tail, and read fetches a single word; the entry memory
// moves or compares one word per cycle.
// Reset clears the entry count; stored words need no clearing.
// A finished result sits in the output register while the next beat is taken;
// a further result waits in the sequencer until that register frees.
// ----------------------------------------------------------------------------
module indexed_sequence_store_top import iss_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op, position, value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status, found_position, read_value, count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic                  res_valid;
  logic                  res_take;
  res_t                  res;
  logic                  out_valid_r;
  res_t                  out_res_r;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [VALUE_BITS-1:0] mem_q;
  logic                  mem_wr_en;
  logic [AW-1:0]         mem_wr_addr;
  logic [VALUE_BITS-1:0] mem_wr_data;

  iss_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (in_tvalid),
    .cmd_ready   (in_tready),
    .cmd_op      (in_tdata[2:0]),
    .cmd_pos     (in_tdata[9:3]),
    .cmd_value   (in_tdata[41:10]),
    .res_valid   (res_valid),
    .res_take    (res_take),
    .res         (res),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_q       (mem_q),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  iss_mem #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .AW         (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_q),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign res_take = res_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

endmodule

[rtl/iss_mem.sv]
// ----------------------------------------------------------------------------
// iss_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module iss_mem #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32,
  parameter int AW         = 6
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output logic [VALUE_BITS-1:0] rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data
);

  logic [VALUE_BITS-1:0] mem_r [DEPTH];
  logic [VALUE_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule

[rtl/iss_ctrl.sv]
// ----------------------------------------------------------------------------
// iss_ctrl
// Operation sequencer: decodes a beat, walks the entry memory one word a
// cycle to shift, search or read, and holds the result until it is taken.
// ----------------------------------------------------------------------------
module iss_ctrl import iss_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32,
  parameter int AW         = 6,
  parameter int CW         = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  logic [OP_BITS-1:0]    cmd_op,
  input  logic [POS_BITS-1:0]   cmd_pos,
  input  logic [WORD_BITS-1:0]  cmd_value,
  output logic                  res_valid,
  input  logic                  res_take,
  output res_t                  res,
  output logic                  mem_rd_en,
  output logic [AW-1:0]         mem_rd_addr,
  input  logic [VALUE_BITS-1:0] mem_q,
  output logic                  mem_wr_en,
  output logic [AW-1:0]         mem_wr_addr,
  output logic [VALUE_BITS-1:0] mem_wr_data
);

  localparam int PW = (CW > POS_BITS) ? CW : POS_BITS;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS      = 3'd1;
  localparam logic [2:0] S_INS_LAST = 3'd2;
  localparam logic [2:0] S_DEL      = 3'd3;
  localparam logic [2:0] S_SRCH     = 3'd4;
  localparam logic [2:0] S_READ     = 3'd5;
  localparam logic [2:0] S_FIN      = 3'd6;

  logic [2:0]             state_r,  state_nxt;
  logic [CW-1:0]          cnt_r,    cnt_nxt;
  logic [AW-1:0]          addr_r,   addr_nxt;
  logic [AW-1:0]          pos_r,    pos_nxt;
  logic [VALUE_BITS-1:0]  key_r,    key_nxt;
  logic [STATUS_BITS-1:0] status_r, status_nxt;
  logic [FOUND_BITS-1:0]  found_r,  found_nxt;
  logic [WORD_BITS-1:0]   rdv_r,    rdv_nxt;

  logic                   full;
  logic [PW-1:0]          posx, cntx;
  logic [AW-1:0]          ins_pos, del_pos;
  logic [VALUE_BITS-1:0]  cmd_word;

  assign full     = (cnt_r == CW'(DEPTH));
  assign posx     = PW'(cmd_pos);
  assign cntx     = PW'(cnt_r);
  assign cmd_word = VALUE_BITS'(cmd_value);

  always_comb begin
    unique case (cmd_op)
      OP_INS_FRONT: ins_pos = '0;
      OP_INS_AT:    ins_pos = AW'(cmd_pos);
      default:      ins_pos = AW'(cnt_r);
    endcase
    unique case (cmd_op)
      OP_DEL_FRONT: del_pos = '0;
      OP_DEL_AT:    del_pos = AW'(cmd_pos);
      default:      del_pos = AW'(cnt_r - CW'(1));
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    addr_nxt    = addr_r;
    pos_nxt     = pos_r;
    key_nxt     = key_r;
    status_nxt  = status_r;
    found_nxt   = found_r;
    rdv_nxt     = rdv_r;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          status_nxt = ST_DONE;
          found_nxt  = '0;
          rdv_nxt    = '0;
          key_nxt    = cmd_word;
          state_nxt  = S_FIN;
          unique case (cmd_op)
            OP_INS_FRONT, OP_INS_AT, OP_INS_TAIL: begin
              if (cmd_op == OP_INS_AT && posx > cntx) begin
                status_nxt = ST_IGNORED;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else if (CW'(ins_pos) == cnt_r) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = ins_pos;
                mem_wr_data = cmd_word;
                cnt_nxt     = cnt_r + CW'(1);
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(cnt_r - CW'(1));
                addr_nxt    = AW'(cnt_r);
                pos_nxt     = ins_pos;
                state_nxt   = S_INS;
              end
            end
            OP_DEL_FRONT, OP_DEL_AT, OP_DEL_TAIL: begin
              if (cnt_r == '0 || (cmd_op == OP_DEL_AT && posx >= cntx)) begin
                status_nxt = ST_IGNORED;
              end else if (CW'(del_pos) + CW'(1) == cnt_r) begin
                cnt_nxt = cnt_r - CW'(1);
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = del_pos + AW'(1);
                addr_nxt    = del_pos;
                state_nxt   = S_DEL;
              end
            end
            OP_SEARCH: begin
              if (cnt_r == '0) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                addr_nxt    = '0;
                state_nxt   = S_SRCH;
              end
            end
            default: begin
              if (posx >= cntx) begin
                status_nxt = ST_IGNORED;
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = AW'(cmd_pos);
                state_nxt   = S_READ;
              end
            end
          endcase
        end
      end
      S_INS: begin
        // move entry addr_r-1 up to addr_r, walking toward the front
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_r;
        mem_wr_data = mem_q;
        addr_nxt    = addr_r - AW'(1);
        if (addr_r - AW'(1) == pos_r) begin
          state_nxt = S_INS_LAST;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = addr_r - AW'(2);
        end
      end
      S_INS_LAST: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pos_r;
        mem_wr_data = key_r;
        cnt_nxt     = cnt_r + CW'(1);
        state_nxt   = S_FIN;
      end
      S_DEL: begin
        // move entry addr_r+1 down to addr_r, walking toward the tail
        mem_wr_en   = 1'b1;
        mem_wr_addr = addr_r;
        mem_wr_data = mem_q;
        addr_nxt    = addr_r + AW'(1);
        if (CW'(addr_r) + CW'(2) == cnt_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_FIN;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = addr_r + AW'(2);
        end
      end
      S_SRCH: begin
        if (mem_q == key_r) begin
          found_nxt = FOUND_BITS'(addr_r);
          state_nxt = S_FIN;
        end else if (CW'(addr_r) + CW'(1) == cnt_r) begin
          status_nxt = ST_NOT_FOUND;
          state_nxt  = S_FIN;
        end else begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = addr_r + AW'(1);
          addr_nxt    = addr_r + AW'(1);
        end
      end
      S_READ: begin
        rdv_nxt   = WORD_BITS'(signed'(mem_q));
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    rdv_r    <= rdv_nxt;
  end

  assign cmd_ready          = (state_r == S_IDLE);
  assign res_valid          = (state_r == S_FIN);
  assign res.status         = status_r;
  assign res.found_position = found_r;
  assign res.read_value     = rdv_r;
  assign res.count          = COUNT_BITS'(cnt_r);

endmodule
